>>> src/fmfax_pkg.sv
`default_nettype none

package fmfax_pkg;

	// Field and register widths
	localparam int SAMPLE_W  = 16;
	localparam int DEV_W     = 12;
	localparam int LEVEL_W   = 10;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BW      = 2'd2;

	localparam logic [DEV_W-1:0] DEV_RESET = 12'd400;

	// Phase and scaling
	localparam int SAMPLE_RATE  = 12000;
	localparam int SR_W         = $clog2(SAMPLE_RATE) + 1;
	localparam int PHASE_BITS   = 16;
	localparam int ANG_W        = 32;
	localparam int XY_W         = 36;
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int MUL_STEPS    = 5;

	// Shared multiplier operand widths
	localparam int MA_W   = (PHASE_BITS > SAMPLE_W) ? PHASE_BITS : SAMPLE_W;
	localparam int MB_W   = (SR_W > SAMPLE_W) ? SR_W : SAMPLE_W;
	localparam int PROD_W = MA_W + MB_W;

	// Level division
	localparam int F_W   = PHASE_BITS + SR_W;
	localparam int D_W   = DEV_W + PHASE_BITS;
	localparam int N_W   = ((F_W > D_W) ? F_W : D_W) + 9;
	localparam int QUO_W = 8;
	localparam int QIX_W = $clog2(QUO_W);

	localparam logic [QUO_W-1:0]          LEVEL_MID   = 8'd127;
	localparam logic signed [LEVEL_W-1:0] LEVEL_FLIP  = 10'sd256;
	localparam logic signed [LEVEL_W-1:0] LEVEL_THR   = 10'sd128;
	localparam logic signed [LEVEL_W-1:0] LEVEL_WHITE = 10'sd255;
	localparam logic signed [LEVEL_W-1:0] LEVEL_BLACK = 10'sd0;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN   = -10'sd1;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX   = 10'sd257;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [ANG_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

endpackage

`default_nettype wire

>>> src/fm_fax_pixel_demodulator.sv
`default_nettype none

// FM fax pixel demodulator. Each input beat is one complex baseband sample
// (sample_i, sample_q); each output beat is one pixel_level, derived from the
// phase step between this sample and the previous one: conj(prev) * cur is
// formed, its angle found by a vectoring CORDIC as a fraction of a turn,
// scaled by the sample rate to Hz, clamped to +-max_deviation_hz and mapped to
// f/dev*128+127 (truncated toward zero), then optionally inverted (256 - level)
// and thresholded at 128 to 255/0 in black-white mode. The previous sample
// resets to zero, so the first level is 127. One item is in flight at a time:
// in_stall is high from acceptance until the result is loaded into the output
// register. A zero product skips the normalize loop and the CORDIC, and a zero
// deviation skips the divider. The normalize loop doubles the product one bit
// per cycle until it reaches 2^29; the angle then takes 30 CORDIC iterations
// through one shared add/shift unit and the level an 8-step restoring divider.
// A finished level waits in the output register while the next sample is
// accepted. Registers: 0 max_deviation_hz (reset 400), 1 invert_level,
// 2 black_white; write them only while the block is idle.
module fm_fax_pixel_demodulator (
	input  wire  logic                                  clk,
	input  wire  logic                                  arst_n,
	// sample channel
	input  wire  logic                                  in_valid,
	output       logic                                  in_stall,
	input  wire  logic signed [fmfax_pkg::SAMPLE_W-1:0] sample_i,
	input  wire  logic signed [fmfax_pkg::SAMPLE_W-1:0] sample_q,
	// level channel
	output       logic                                  out_valid,
	input  wire  logic                                  out_stall,
	output       logic signed [fmfax_pkg::LEVEL_W-1:0]  pixel_level,
	// register writes
	input  wire  logic                                  cfg_we,
	input  wire  logic [fmfax_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  logic [fmfax_pkg::DEV_W-1:0]           cfg_data
);
	import fmfax_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MUL   = 9'b000000010,
		ST_NORM  = 9'b000000100,
		ST_ROT   = 9'b000001000,
		ST_RND   = 9'b000010000,
		ST_SCALE = 9'b000100000,
		ST_NUMER = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	localparam logic signed [MB_W-1:0] SR_OP   = MB_W'(SAMPLE_RATE);
	localparam logic [XY_W-1:0]        NORM_LIM = XY_W'(64'd1 << 29);
	localparam logic [ANG_W-1:0]       ANG_HALF = 32'h8000_0000;
	localparam logic [ANG_W-1:0]       ANG_RND  = ANG_W'(64'd1 << (ANG_W - 1 - PHASE_BITS));

	state_t                    state_q;
	logic [STEP_W-1:0]         cnt_q;

	logic [DEV_W-1:0]          dev_q;
	logic                      invert_q;
	logic                      bw_q;

	logic signed [SAMPLE_W-1:0] cur_i_q, cur_q_q;
	logic signed [SAMPLE_W-1:0] prev_i_q, prev_q_q;

	logic signed [PROD_W-1:0]  prod_q;
	logic signed [XY_W-1:0]    x_q, y_q;
	logic [ANG_W-1:0]          ang_q;
	logic signed [PHASE_BITS-1:0] phase_q;
	logic [N_W-1:0]            rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic                      neg_q;

	logic                      out_valid_q;
	logic signed [LEVEL_W-1:0] pixel_q;

	// shared multiplier operands
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;

	// datapath helpers
	logic signed [XY_W-1:0]    prod_xy;
	logic [XY_W-1:0]           ax, ay;
	logic                      xy_zero, xy_small;
	logic signed [XY_W-1:0]    dx, dy;
	logic [ANG_W-1:0]          ang_r;
	logic signed [N_W-1:0]     f_raw, d_s, f_cl, n_val;
	logic [N_W-1:0]            d_u, d_sh;
	logic signed [LEVEL_W-1:0] lvl_div, lvl_inv, lvl_fin;
	logic                      out_free;

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign pixel_level = pixel_q;
	assign out_free    = !out_valid_q || !out_stall;

	// operand select: four cross products, then phase * sample rate
	always_comb begin
		if (state_q == ST_SCALE) begin
			mul_a = MA_W'(phase_q);
			mul_b = SR_OP;
		end else begin
			mul_a = cnt_q[0] ? MA_W'(prev_q_q) : MA_W'(prev_i_q);
			mul_b = (cnt_q[1] ^ cnt_q[0]) ? MB_W'(cur_q_q) : MB_W'(cur_i_q);
		end
	end

	assign prod_xy  = XY_W'(prod_q);
	assign ax       = x_q[XY_W-1] ? XY_W'(-x_q) : XY_W'(x_q);
	assign ay       = y_q[XY_W-1] ? XY_W'(-y_q) : XY_W'(y_q);
	assign xy_zero  = (x_q == '0) && (y_q == '0);
	assign xy_small = (ax < NORM_LIM) && (ay < NORM_LIM);
	assign dx       = x_q >>> cnt_q;
	assign dy       = y_q >>> cnt_q;
	assign ang_r    = ang_q + ANG_RND;

	// frequency clamp and numerator 128*F + 127*D
	assign d_u   = N_W'({dev_q, {PHASE_BITS{1'b0}}});
	assign d_s   = $signed(d_u);
	assign f_raw = N_W'(prod_q);
	always_comb begin
		priority if (f_raw > d_s)
			f_cl = d_s;
		else if (f_raw < -d_s)
			f_cl = -d_s;
		else
			f_cl = f_raw;
	end
	assign n_val = (f_cl <<< 7) + (d_s <<< 7) - d_s;
	assign d_sh  = d_u << cnt_q;

	// level post-processing
	assign lvl_div = neg_q ? -$signed(LEVEL_W'(quo_q)) : $signed(LEVEL_W'(quo_q));
	assign lvl_inv = invert_q ? (LEVEL_FLIP - lvl_div) : lvl_div;
	assign lvl_fin = bw_q ? ((lvl_inv >= LEVEL_THR) ? LEVEL_WHITE : LEVEL_BLACK) : lvl_inv;

	// control state, registers, previous sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			dev_q       <= DEV_RESET;
			invert_q    <= 1'b0;
			bw_q        <= 1'b0;
			prev_i_q    <= '0;
			prev_q_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_DEV: dev_q    <= cfg_data;
					REG_INVERT:  invert_q <= cfg_data[0];
					REG_BW:      bw_q     <= cfg_data[0];
					default: ;
				endcase
			end

			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
						prev_i_q <= cur_i_q;
						prev_q_q <= cur_q_q;
						state_q  <= ST_NORM;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_NORM: begin
					priority if (xy_zero) begin
						state_q <= ST_SCALE;
					end else if (!xy_small) begin
						cnt_q   <= '0;
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (cnt_q == STEP_W'(CORDIC_STEPS - 1))
						state_q <= ST_RND;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_RND:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_NUMER;
				ST_NUMER: begin
					if (dev_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q   <= STEP_W'(QUO_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_FIN;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: shared multiplier, CORDIC add/shift unit, restoring divider
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cur_i_q <= sample_i;
					cur_q_q <= sample_q;
				end
			end
			ST_MUL: begin
				// products land in the cycle after their operands are selected
				unique case (cnt_q)
					STEP_W'(0): begin
						x_q <= '0;
						y_q <= '0;
					end
					STEP_W'(1), STEP_W'(2): x_q <= x_q + prod_xy;
					STEP_W'(3):             y_q <= y_q + prod_xy;
					default:                y_q <= y_q - prod_xy;
				endcase
			end
			ST_NORM: begin
				priority if (xy_zero) begin
					phase_q <= '0;
				end else if (xy_small) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end else if (x_q[XY_W-1]) begin
					// pre-rotate by a half turn into the right half plane
					x_q   <= -x_q;
					y_q   <= -y_q;
					ang_q <= ANG_HALF;
				end else begin
					ang_q <= '0;
				end
			end
			ST_ROT: begin
				if (y_q > 0) begin
					x_q   <= x_q + dy;
					y_q   <= y_q - dx;
					ang_q <= ang_q + ATAN_TURN[cnt_q];
				end else begin
					x_q   <= x_q - dy;
					y_q   <= y_q + dx;
					ang_q <= ang_q - ATAN_TURN[cnt_q];
				end
			end
			ST_RND: phase_q <= ang_r[ANG_W-1 -: PHASE_BITS];
			ST_NUMER: begin
				quo_q <= (dev_q == '0) ? LEVEL_MID : '0;
				neg_q <= (dev_q != '0) && n_val[N_W-1];
				rem_q <= n_val[N_W-1] ? N_W'(-n_val) : N_W'(n_val);
			end
			ST_DIV: begin
				if (rem_q >= d_sh) begin
					rem_q                   <= rem_q - d_sh;
					quo_q[cnt_q[QIX_W-1:0]] <= 1'b1;
				end
			end
			ST_FIN: begin
				if (out_free)
					pixel_q <= lvl_fin;
			end
			default: ;
		endcase
	end

	// the vector stays in the right half plane through the CORDIC
	a_rot_right_half: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT) |-> !x_q[XY_W-1])
		else $error("CORDIC x went negative");

	// restoring division remainder stays below twice the current trial divisor
	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |->
			({1'b0, rem_q} < ((N_W+1)'(d_u) << (cnt_q + 1'b1))))
		else $error("divider remainder out of range");

	// a negative level can only be -1
	a_neg_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && neg_q) |-> (quo_q <= QUO_W'(1)))
		else $error("negative quotient larger than one");

	// a delivered level lies in the range LEVEL_MIN to LEVEL_MAX (-1 to 257)
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (pixel_q >= LEVEL_MIN && pixel_q <= LEVEL_MAX))
		else $error("pixel level out of range");

endmodule

`default_nettype wire
